/* sv/les_pkg.sv */
// les_pkg: shared constants for the local extrema sum block.
// Result field widths, configuration register indexes and limits.
// No dependencies.
`default_nettype none

package les_pkg;

  // Result field widths
  localparam int SUM_W = 30;
  localparam int CNT_W = 15;

  // Configuration port
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd1;

  // Smallest usable frame dimension, and the reset value of both registers
  localparam logic [CFG_W-1:0] DIM_MIN = 8'd2;

endpackage

`default_nettype wire

/* sv/local_extrema_sum.sv */
// Local extrema sum over a 4-neighborhood. Pixels of a frame enter one item per clock in
// raster order; the block marks every pixel strictly above or strictly below all of its
// existing 4-neighbors (edges and corners use only the neighbors they have, ties never
// count), sums and counts the marked pixels, and on the frame's last pixel emits one
// result item with the sum and the count, then starts the next frame from zero. The block
// sustains one pixel per clock with no gaps, also across frame boundaries, unless a frame's
// last pixel waits in stage 1 while the previous result is still unread; the result goes
// from stage 1 into the output register, and the next frame streams in while that result
// waits there. The neighborhood comes from the two line buffers: each is a chain of
// MAX_COLS-1 cells that shifts once per accepted pixel, with the entry cell chosen from
// frame_cols so that the fixed output tap gives the right delay. Pixels are judged in one
// registered stage and accumulated in the next. Write frame_rows and frame_cols only
// between frames; values below 2 act as 2, above the maximum as the maximum.
// Depends on les_pkg and les_line.
`default_nettype none

module local_extrema_sum
  import les_pkg::*;
#(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 128,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]             cfg_wdata_i,
  // Pixel input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [PIXEL_BITS-1:0] pixel_i,
  // Result output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [SUM_W-1:0]           extrema_sum_o,
  output logic        [CNT_W-1:0]           extrema_count_o
);

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CDIM_W = $clog2(MAX_COLS + 1);
  localparam int RDIM_W = $clog2(MAX_ROWS + 1);
  localparam int ENT_W  = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_COLS - 1;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;

  // Strict extremum test against the neighbors flagged as present.
  function automatic logic judge(input pix_t ctr, input pix_t nb [4],
                                 input logic [3:0] has);
    logic gt;
    logic lt;
    gt = 1'b1;
    lt = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (has[k]) begin
        if (!($signed(ctr) > $signed(nb[k]))) gt = 1'b0;
        if (!($signed(ctr) < $signed(nb[k]))) lt = 1'b0;
      end
    end
    return (|has) && (gt || lt);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers and effective frame size
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  frame_rows_q, frame_cols_q;
  logic [RDIM_W-1:0] rows_eff;
  logic [CDIM_W-1:0] cols_eff;
  logic [ENT_W-1:0]  entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= DIM_MIN;
      frame_cols_q <= DIM_MIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_ROWS: frame_rows_q <= cfg_wdata_i;
        REG_FRAME_COLS: frame_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp to [2, max]
  always_comb begin
    if (frame_rows_q < DIM_MIN) begin
      rows_eff = RDIM_W'(DIM_MIN);
    end else if (32'(frame_rows_q) > 32'(MAX_ROWS)) begin
      rows_eff = RDIM_W'(MAX_ROWS);
    end else begin
      rows_eff = RDIM_W'(frame_rows_q);
    end
    if (frame_cols_q < DIM_MIN) begin
      cols_eff = CDIM_W'(DIM_MIN);
    end else if (32'(frame_cols_q) > 32'(MAX_COLS)) begin
      cols_eff = CDIM_W'(MAX_COLS);
    end else begin
      cols_eff = CDIM_W'(frame_cols_q);
    end
  end

  // Entry cell of both line chains: the last cell then sits cols-1 items back
  assign entry = ENT_W'(32'(MAX_COLS) - 32'(cols_eff));

  // ---------------------------------------------------------------------------
  // Handshake and position
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic s1_valid_q, s1_last_q, s1_adv, take;

  // Hold stage 1 only when it carries a frame end and the output is still occupied
  assign s1_adv     = !s1_last_q || !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;
  assign take       = s1_valid_q && s1_adv;

  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             last_row, last_col;
  logic             row_ge1, row_ge2, col_ge1, col_ge2;

  assign last_row = (32'(row_q) + 32'd1) >= 32'(rows_eff);
  assign last_col = (32'(col_q) + 32'd1) >= 32'(cols_eff);
  assign row_ge1  = 32'(row_q) >= 32'd1;
  assign row_ge2  = 32'(row_q) >= 32'd2;
  assign col_ge1  = 32'(col_q) >= 32'd1;
  assign col_ge2  = 32'(col_q) >= 32'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Neighborhood: two cell chains plus a few taps
  //   tap_a : pixel cols-1 items back (right neighbor of the judged pixel)
  //   up_q  : cols items back (the pixel above the incoming one)
  //   ul_q  : cols+1 items back
  //   tap_b : 2*cols items back (two rows up)
  //   w0_q, w1_q : the previous two pixels of the current row
  // ---------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] tap_a_raw, tap_b_raw;
  pix_t                  tap_a, tap_b;
  pix_t                  up_q, ul_q, w0_q, w1_q;

  les_line #(
    .PIXEL_BITS(PIXEL_BITS),
    .DEPTH     (DEPTH),
    .ENT_W     (ENT_W)
  ) u_line_a (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .entry_i(entry),
    .pix_i  (pixel_i),
    .tap_o  (tap_a_raw)
  );

  les_line #(
    .PIXEL_BITS(PIXEL_BITS),
    .DEPTH     (DEPTH),
    .ENT_W     (ENT_W)
  ) u_line_b (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .entry_i(entry),
    .pix_i  (ul_q),
    .tap_o  (tap_b_raw)
  );

  assign tap_a = pix_t'(tap_a_raw);
  assign tap_b = pix_t'(tap_b_raw);

  // Advance the taps with each accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      up_q <= tap_a;
      ul_q <= up_q;
      w1_q <= w0_q;
      w0_q <= pixel_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: judge up to three pixels per item
  //   above   : pixel above the incoming one, now that its lower neighbor is here
  //   left    : in the last row, the previous pixel once its right neighbor arrives
  //   current : the frame's last pixel, judged on arrival
  // ---------------------------------------------------------------------------
  logic [2:0] mark;
  pix_t       s1_val_q [3];
  logic [2:0] s1_mark_q;

  always_comb begin
    mark[0] = row_ge1 &&
              judge(up_q, '{tap_b, ul_q, tap_a, pixel_i},
                    {1'b1, !last_col, col_ge1, row_ge2});
    mark[1] = last_row && col_ge1 &&
              judge(w0_q, '{ul_q, w1_q, pixel_i, pixel_i},
                    {1'b0, 1'b1, col_ge2, 1'b1});
    mark[2] = last_row && last_col &&
              judge(pixel_i, '{up_q, w0_q, pixel_i, pixel_i},
                    {2'b00, col_ge1, 1'b1});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc;
      s1_last_q  <= in_acc && last_row && last_col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mark_q   <= mark;
      s1_val_q[0] <= up_q;
      s1_val_q[1] <= w0_q;
      s1_val_q[2] <= pixel_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: accumulate, hand the frame total to the output register
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] add_val [3];
  logic             out_valid_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [CNT_W-1:0] out_cnt_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_val[i] = s1_mark_q[i] ? SUM_W'(32'(s1_val_q[i])) : '0;
    end
    sum_d = sum_q + add_val[0] + add_val[1] + add_val[2];
    cnt_d = cnt_q + CNT_W'(s1_mark_q[0]) + CNT_W'(s1_mark_q[1]) + CNT_W'(s1_mark_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new frame total refills the output register, else drop the taken one
      if (take && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        if (s1_last_q) begin
          // Frame done: ship the total and restart from zero
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && s1_last_q) begin
      out_sum_q <= sum_d;
      out_cnt_q <= cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign extrema_sum_o   = $signed(out_sum_q);
  assign extrema_count_o = out_cnt_q;

endmodule

`default_nettype wire

/* sv/les_cell.sv */
// les_cell: one stage of a pixel delay line.
// Loads the incoming pixel when it is the entry stage, else its neighbor.
// No dependencies.
`default_nettype none

module les_cell #(
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic                  entry_i,
  input  wire logic [PIXEL_BITS-1:0] new_pix_i,
  input  wire logic [PIXEL_BITS-1:0] prev_pix_i,
  output logic      [PIXEL_BITS-1:0] pix_o
);

  logic [PIXEL_BITS-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= entry_i ? new_pix_i : prev_pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

/* sv/les_line.sv */
// les_line: line buffer built as a row of les_cell stages.
// The entry stage sets the delay; the output tap is always the last stage.
// Depends on les_cell.
`default_nettype none

module les_line #(
  parameter int PIXEL_BITS = 16,
  parameter int DEPTH      = 127,
  parameter int ENT_W      = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [ENT_W-1:0]      entry_i,
  input  wire logic [PIXEL_BITS-1:0] pix_i,
  output logic      [PIXEL_BITS-1:0] tap_o
);

  logic [PIXEL_BITS-1:0] stage_pix [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [PIXEL_BITS-1:0] prev_pix;

    if (k == 0) begin : g_head
      assign prev_pix = pix_i;
    end else begin : g_body
      assign prev_pix = stage_pix[k-1];
    end

    les_cell #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .en_i      (en_i),
      .entry_i   (entry_i == ENT_W'(k)),
      .new_pix_i (pix_i),
      .prev_pix_i(prev_pix),
      .pix_o     (stage_pix[k])
    );
  end

  assign tap_o = stage_pix[DEPTH-1];

endmodule

`default_nettype wire

/* sv/les_check.sv */
// les_check: port-level checks for local_extrema_sum, attached by bind.
// Depends on les_pkg and on the local_extrema_sum ports.
`default_nettype none

module les_check
  import les_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic signed [SUM_W-1:0] extrema_sum_i,
  input wire logic [CNT_W-1:0]       extrema_count_i
);

  // Drop any result once reset has been seen at a clock edge
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid after reset");

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(extrema_sum_i) && $stable(extrema_count_i))
    else $error("stalled result changed");

  // A free output side never blocks the pixel stream
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled while output side is free");

  // A fresh result follows an accepted item that has passed stage 1 and the output register
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a frame end item");

  // No extrema means nothing summed
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && extrema_count_i == '0 |-> extrema_sum_i == '0)
    else $error("nonzero sum with zero count");

endmodule

bind local_extrema_sum les_check u_les_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .extrema_sum_i  (extrema_sum_o),
  .extrema_count_i(extrema_count_o)
);

`default_nettype wire

/* verif/tb.sv */
// Testbench for local_extrema_sum: streams pixel frames through the block, predicts
// the per-frame sum and count of strict local extrema and checks every result item.
// Depends on les_pkg and the local_extrema_sum RTL.
`timescale 1ns / 100ps

module tb;
  import les_pkg::*;

  localparam int PIX_W      = 16;
  localparam int DIM_MAX    = 128;
  // Random part only; the directed and geometry-extreme frames add about 540 items
  localparam int RAND_ITEMS = 560;
  localparam int DIR_ROWS   = 5;

  // Pixel patterns a frame can be filled with
  typedef enum logic [2:0] {
    FILL_CONST,
    FILL_CHECKER,
    FILL_RAMP,
    FILL_PEAK,
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RAILS
  } fill_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] ext_sum;
    logic        [CNT_W-1:0] ext_cnt;
  } frame_result_t;

  // One directed frame: geometry, fill pattern, and a typed-in result where obvious
  typedef struct packed {
    logic [CFG_W-1:0]        rows;
    logic [CFG_W-1:0]        cols;
    logic                    wr_cfg;
    fill_e                   kind;
    logic signed [PIX_W-1:0] a;
    logic signed [PIX_W-1:0] b;
    logic                    typed;
    logic signed [SUM_W-1:0] exp_sum;
    logic        [CNT_W-1:0] exp_cnt;
  } dir_frame_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx   = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic signed [PIX_W-1:0] pixel     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] extrema_sum;
  logic        [CNT_W-1:0] extrema_count;

  // Predictor state: two line buffers, the last two pixels of the row, position,
  // running totals and the frame geometry registers
  logic signed [PIX_W-1:0] line_old [DIM_MAX];
  logic signed [PIX_W-1:0] line_new [DIM_MAX];
  logic signed [PIX_W-1:0] prev_px;
  logic signed [PIX_W-1:0] prev2_px;
  int unsigned             pos_row;
  int unsigned             pos_col;
  logic signed [SUM_W-1:0] acc_sum;
  logic        [CNT_W-1:0] acc_cnt;
  logic [CFG_W-1:0]        reg_rows;
  logic [CFG_W-1:0]        reg_cols;

  frame_result_t           frame_results_q [$];
  frame_result_t           typed_res;
  bit                      use_typed;
  bit                      idle_on;
  int                      burst_left;
  int                      err_count;
  dir_frame_t              dir_tab [DIR_ROWS];

  logic [31:0]             stall_pat;
  int                      pat_phase;

  local_extrema_sum u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pixel_i         (pixel),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .extrema_sum_o   (extrema_sum),
    .extrema_count_o (extrema_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: end the run if the block stops moving
  initial begin
    #10_000_000;
    $display("[local_extrema_sum] ERROR");
    $finish;
  end

  // Receiver: replay a 32-bit ready pattern bit by bit, reload it every lap. One lap in four
  // is always-ready so that stretches with no back-pressure occur too.
  always @(negedge clk) begin
    if (pat_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = $urandom() | $urandom();
        default: stall_pat = $urandom();
      endcase
    end
    out_ready = stall_pat[pat_phase];
    pat_phase = (pat_phase + 1) % 32;
  end

  // Clamp a geometry register the way the block does
  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v);
    if (v < DIM_MIN) return int'(DIM_MIN);
    if (v > DIM_MAX) return DIM_MAX;
    return int'(v);
  endfunction

  // Mark ctr if it is strictly above or strictly below every present neighbor
  task automatic judge_px(input logic signed [PIX_W-1:0] ctr,
                          input logic signed [PIX_W-1:0] n0, n1, n2, n3,
                          input logic [3:0] has);
    logic signed [PIX_W-1:0] nb [4];
    bit above;
    bit below;
    int k;
    nb[0] = n0;
    nb[1] = n1;
    nb[2] = n2;
    nb[3] = n3;
    above = 1'b1;
    below = 1'b1;
    for (k = 0; k < 4; k++) begin
      if (has[k]) begin
        if (!(ctr > nb[k])) above = 1'b0;
        if (!(ctr < nb[k])) below = 1'b0;
      end
    end
    if (has != 4'b0000 && (above || below)) begin
      acc_sum = acc_sum + ctr;
      acc_cnt = acc_cnt + 1'b1;
    end
  endtask

  // Advance the predictor by one accepted pixel; flag the frame result on the last one
  task automatic predict_extrema(input logic signed [PIX_W-1:0] px,
                                 output bit got, output frame_result_t res);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned r;
    int unsigned c;
    int unsigned cl;
    int unsigned cr;
    bit lastc;
    bit lastr;
    nrows = eff_dim(reg_rows);
    ncols = eff_dim(reg_cols);
    r = pos_row;
    c = pos_col;
    lastc = (c >= ncols - 1);
    lastr = (r >= nrows - 1);
    cl = (c == 0) ? 0 : c - 1;
    cr = lastc ? c : c + 1;
    got = 1'b0;
    res = '0;
    // Pixel above the incoming one now has its lower neighbor
    if (r >= 1)
      judge_px(line_new[c], line_old[c], line_old[cl], line_new[cr], px,
               {1'b1, !lastc, c >= 1, r >= 2});
    // Last row: the previous pixel now has its right neighbor
    if (lastr && c >= 1)
      judge_px(prev_px, line_old[cl], prev2_px, px, '0, {2'b01, c >= 2, 1'b1});
    // Last pixel of the frame is judged on arrival
    if (lastr && lastc)
      judge_px(px, line_new[c], prev_px, '0, '0, {2'b00, c >= 1, 1'b1});

    line_old[c] = line_new[c];
    line_new[c] = px;
    prev2_px = prev_px;
    prev_px = px;

    if (lastc) begin
      pos_col = 0;
      if (lastr) begin
        got = 1'b1;
        res.ext_sum = acc_sum;
        res.ext_cnt = acc_cnt;
        pos_row = 0;
        acc_sum = '0;
        acc_cnt = '0;
      end else begin
        pos_row = (r + 1) % DIM_MAX;
      end
    end else begin
      pos_col = c + 1;
    end
  endtask

  function automatic logic signed [PIX_W-1:0] make_pixel(fill_e kind,
                                                         logic signed [PIX_W-1:0] a, b,
                                                         int unsigned r, c, ncols);
    int v;
    case (kind)
      FILL_CONST:   v = a;
      FILL_CHECKER: v = ((r + c) % 2 == 0) ? a : b;
      FILL_RAMP:    v = a + int'(r * ncols + c);
      FILL_PEAK:    v = (r == 1 && c == 1) ? b : a;
      FILL_NARROW:  v = a + int'($urandom_range(0, 4)) - 2;
      FILL_RAILS: begin
        case ($urandom_range(0, 3))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 32766;
          default: v = -32767;
        endcase
      end
      default:      v = $urandom();
    endcase
    return v[PIX_W-1:0];
  endfunction

  // Offer one pixel item, keeping valid up across items unless a gap is due
  task automatic send_pixel(input logic signed [PIX_W-1:0] px);
    bit got;
    frame_result_t res;
    if (idle_on && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid = 1'b1;
    pixel = px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_extrema(px, got, res);
    if (got) frame_results_q.push_back(use_typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic send_frame(input fill_e kind, input logic signed [PIX_W-1:0] a, b);
    int unsigned nrows;
    int unsigned ncols;
    int unsigned r;
    int unsigned c;
    nrows = eff_dim(reg_rows);
    ncols = eff_dim(reg_cols);
    for (r = 0; r < nrows; r++)
      for (c = 0; c < ncols; c++)
        send_pixel(make_pixel(kind, a, b, r, c, ncols));
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic wait_drained();
    in_valid = 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_FRAME_ROWS) reg_rows = data;
    else reg_cols = data;
  endtask

  // Mostly small frames, sometimes below the minimum, rarely a bit larger
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return 8'($urandom_range(0, 1));
      1:       return 8'($urandom_range(9, 16));
      default: return 8'($urandom_range(2, 8));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Compare each accepted result item with the oldest expected frame result
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result: sum %0d, count %0d",
                   $time, extrema_sum, extrema_count);
      end else begin
        want = frame_results_q.pop_front();
        if (extrema_sum !== want.ext_sum)
          flag_mismatch("extrema_sum", want.ext_sum, extrema_sum);
        if (extrema_count !== want.ext_cnt)
          flag_mismatch("extrema_count", want.ext_cnt, extrema_count);
      end
    end
  end

  initial begin : stimulus
    int i;
    int rand_items;
    int wait_cnt;
    fill_e kind;
    logic signed [PIX_W-1:0] fa;
    logic signed [PIX_W-1:0] fb;

    for (i = 0; i < DIM_MAX; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    prev_px = '0;
    prev2_px = '0;
    pos_row = 0;
    pos_col = 0;
    acc_sum = '0;
    acc_cnt = '0;
    reg_rows = DIM_MIN;
    reg_cols = DIM_MIN;
    use_typed = 1'b0;
    idle_on = 1'b1;
    burst_left = 0;
    err_count = 0;
    rand_items = 0;

    // Directed frames: all ties, rail checkerboard, clamped-low geometry with a ramp,
    // single valley in a flat 3x3, and one small random frame
    dir_tab[0] = '{8'd2, 8'd2, 1'b0, FILL_CONST, 16'sd0, 16'sd0, 1'b1, 30'sd0, 15'd0};
    dir_tab[1] = '{8'd2, 8'd2, 1'b0, FILL_CHECKER, 16'sd32767, -16'sd32768,
                   1'b1, -30'sd2, 15'd4};
    dir_tab[2] = '{8'd0, 8'd1, 1'b1, FILL_RAMP, 16'sd1, 16'sd0, 1'b1, 30'sd5, 15'd2};
    dir_tab[3] = '{8'd3, 8'd3, 1'b1, FILL_PEAK, 16'sd5, -16'sd32768,
                   1'b1, -30'sd32768, 15'd1};
    dir_tab[4] = '{8'd2, 8'd3, 1'b1, FILL_RANDOM, 16'sd0, 16'sd0, 1'b0, 30'sd0, 15'd0};

    // Hold reset, then release it away from the rising edge
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].wr_cfg) begin
        wait_drained();
        write_reg(REG_FRAME_ROWS, dir_tab[i].rows);
        write_reg(REG_FRAME_COLS, dir_tab[i].cols);
      end
      use_typed = dir_tab[i].typed;
      typed_res.ext_sum = dir_tab[i].exp_sum;
      typed_res.ext_cnt = dir_tab[i].exp_cnt;
      send_frame(dir_tab[i].kind, dir_tab[i].a, dir_tab[i].b);
    end
    use_typed = 1'b0;

    // Geometry extremes: all ones clamps rows to the maximum; widest legal row
    wait_drained();
    write_reg(REG_FRAME_ROWS, 8'd255);
    write_reg(REG_FRAME_COLS, 8'd2);
    send_frame(FILL_RANDOM, '0, '0);
    wait_drained();
    write_reg(REG_FRAME_ROWS, 8'd2);
    write_reg(REG_FRAME_COLS, 8'd128);
    send_frame(FILL_RAILS, '0, '0);

    // Random frames; reconfigure between some of them, stream others back to back
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_ROWS, pick_dim());
        if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_COLS, pick_dim());
      end
      idle_on = ($urandom_range(0, 3) != 0);
      fa = $urandom();
      fb = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = FILL_RANDOM;
        4, 5:       kind = FILL_NARROW;
        6:          kind = FILL_RAILS;
        7:          kind = FILL_CHECKER;
        8:          kind = FILL_PEAK;
        default:    kind = FILL_CONST;
      endcase
      send_frame(kind, fa, fb);
      rand_items += eff_dim(reg_rows) * eff_dim(reg_cols);
    end

    // Drain: wait for outstanding results, bounded, then a short settle
    in_valid = 1'b0;
    wait_cnt = 0;
    while (frame_results_q.size() != 0 && wait_cnt < 10000) begin
      @(negedge clk);
      wait_cnt++;
    end
    if (frame_results_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d frame results never arrived", $time, frame_results_q.size());
    end
    repeat (20) @(negedge clk);

    if (err_count == 0)
      $display("[local_extrema_sum] OK");
    else
      $display("[local_extrema_sum] ERROR");
    $finish;
  end

endmodule

/* local_extrema_sum.f */
sv/les_pkg.sv
sv/les_cell.sv
sv/les_line.sv
sv/local_extrema_sum.sv
sv/les_check.sv
verif/tb.sv
